@@ hw/rtl/b2sd_pkg.sv @@
// ----------------------------------------------------------------------------
// b2sd_pkg
// Shared types, constants and the numeral script table for the decimal
// digit writer.
// ----------------------------------------------------------------------------
package b2sd_pkg;

    localparam int VALUE_W     = 64;  // input word width
    localparam int FULL_DIGITS = 20;  // decimal digits of the widest input
    localparam int ND_W        = 5;   // digit count, 1..20
    localparam int LEN_W       = 6;   // string length in bytes, up to 60
    localparam int CNT_W       = 6;   // shift step counter, 0..63
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_NUMERAL_SYSTEM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BYTES   = 1'd1;

    localparam logic [3:0] SYS_DEVANAGARI = 4'd0;
    localparam logic [3:0] SYS_GUJARATI   = 4'd1;
    localparam logic [3:0] SYS_GURMUKHI   = 4'd2;
    localparam logic [3:0] SYS_TIBETAN    = 4'd3;
    localparam logic [3:0] SYS_BENGALI    = 4'd4;
    localparam logic [3:0] SYS_KANNADA    = 4'd5;
    localparam logic [3:0] SYS_ODIA       = 4'd6;
    localparam logic [3:0] SYS_MALAYALAM  = 4'd7;
    localparam logic [3:0] SYS_TAMIL      = 4'd8;
    localparam logic [3:0] SYS_TELUGU     = 4'd9;
    localparam logic [3:0] SYS_KHMER      = 4'd10;
    localparam logic [3:0] SYS_THAI       = 4'd11;
    localparam logic [3:0] SYS_LAO        = 4'd12;
    localparam logic [3:0] SYS_BURMESE    = 4'd13;
    localparam logic [3:0] SYS_ARABIC     = 4'd14;
    localparam logic [3:0] SYS_PERSIAN    = 4'd15;

    typedef struct packed {
        logic [BYTE_W-1:0] lead0;
        logic [BYTE_W-1:0] lead1;
        logic [BYTE_W-1:0] zero;
        logic              three;  // 3 bytes per digit, else 2
    } script_t;

    // Classification of one converted item
    typedef struct packed {
        logic             ovf;
        logic [LEN_W-1:0] total;
        logic [ND_W-1:0]  nd;
    } info_t;

    function automatic script_t script_lookup(input logic [3:0] sys);
        script_t s;
        unique case (sys)
            SYS_DEVANAGARI: s = '{8'hE0, 8'hA5, 8'hA6, 1'b1};
            SYS_GUJARATI:   s = '{8'hE0, 8'hAB, 8'hA6, 1'b1};
            SYS_GURMUKHI:   s = '{8'hE0, 8'hA9, 8'hA6, 1'b1};
            SYS_TIBETAN:    s = '{8'hE0, 8'hBC, 8'hA0, 1'b1};
            SYS_BENGALI:    s = '{8'hE0, 8'hA7, 8'hA6, 1'b1};
            SYS_KANNADA:    s = '{8'hE0, 8'hB3, 8'hA6, 1'b1};
            SYS_ODIA:       s = '{8'hE0, 8'hAD, 8'hA6, 1'b1};
            SYS_MALAYALAM:  s = '{8'hE0, 8'hB5, 8'hA6, 1'b1};
            SYS_TAMIL:      s = '{8'hE0, 8'hAF, 8'hA6, 1'b1};
            SYS_TELUGU:     s = '{8'hE0, 8'hB1, 8'hA6, 1'b1};
            SYS_KHMER:      s = '{8'hE1, 8'h9F, 8'hA0, 1'b1};
            SYS_THAI:       s = '{8'hE0, 8'hB9, 8'h90, 1'b1};
            SYS_LAO:        s = '{8'hE0, 8'hBB, 8'h90, 1'b1};
            SYS_BURMESE:    s = '{8'hE1, 8'h81, 8'h80, 1'b1};
            SYS_ARABIC:     s = '{8'hD9, 8'h00, 8'hA0, 1'b0};
            SYS_PERSIAN:    s = '{8'hDB, 8'h00, 8'hB0, 1'b0};
            default:        s = '{8'hE0, 8'hA5, 8'hA6, 1'b1};
        endcase
        return s;
    endfunction

endpackage

@@ hw/rtl/b2sd_front.sv @@
// ----------------------------------------------------------------------------
// b2sd_front
// Accepts a value, converts it to BCD by shift-and-add-3 (one bit per
// cycle), counts its digits and checks the fit against the buffer size.
// ----------------------------------------------------------------------------
module b2sd_front #(
    parameter int MAX_DIGITS = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [b2sd_pkg::VALUE_W-1:0]      value,
    input  logic [3:0]                        numeral_system,
    input  logic [7:0]                        buffer_bytes,
    output logic                              q_push,
    input  logic                              q_full,
    output b2sd_pkg::info_t                   q_info,
    output logic [MAX_DIGITS-1:0][3:0]        q_digits
);
    import b2sd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [VALUE_W-1:0]           sh_reg, sh_next;
    logic [FULL_DIGITS-1:0][3:0]  bcd_reg, bcd_next;
    logic [FULL_DIGITS-1:0][3:0]  bcd_adj;
    logic [ND_W-1:0]              nd;
    logic [LEN_W-1:0]             total;
    script_t                      scr;

    always_comb
    begin
        for (int i = 0; i < FULL_DIGITS; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    // digit count and length
    always_comb
    begin
        nd = ND_W'(1);
        for (int i = 0; i < FULL_DIGITS; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                nd = ND_W'(i + 1);
            end
        end
    end

    assign scr   = script_lookup(numeral_system);
    assign total = scr.three ? LEN_W'({nd, 1'b0}) + LEN_W'(nd) : LEN_W'({nd, 1'b0});

    assign q_info.nd    = nd;
    assign q_info.total = total;
    assign q_info.ovf   = (nd > ND_W'(MAX_DIGITS)) ||
                          ((8'(total) + 8'd1) > buffer_bytes);
    assign q_digits     = bcd_reg[MAX_DIGITS-1:0];

    assign full   = (state_reg != S_IDLE);
    assign q_push = (state_reg == S_DONE) && !q_full;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sh_next    = sh_reg;
        bcd_next   = bcd_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (push)
                begin
                    sh_next    = value;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                // top digit never exceeds 1 for a 64-bit input, so its carry-out is dropped
                bcd_next = (4*FULL_DIGITS)'({bcd_adj, sh_reg[VALUE_W-1]});
                sh_next  = {sh_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VALUE_W - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!q_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        bcd_reg <= bcd_next;
    end

endmodule

@@ hw/rtl/b2sd_queue.sv @@
// ----------------------------------------------------------------------------
// b2sd_queue
// Two-entry queue between the converter and the byte emitter.
// ----------------------------------------------------------------------------
module b2sd_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  logic [W-1:0] wdata,
    output logic         q_full,
    input  logic         rd,
    output logic [W-1:0] rdata,
    output logic         q_empty
);
    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         do_wr, do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ hw/rtl/b2sd_back.sv @@
// ----------------------------------------------------------------------------
// b2sd_back
// Takes converted queue items and emits their UTF-8 bytes, most significant
// digit first, into an output register, one byte per cycle while pop is held.
// ----------------------------------------------------------------------------
module b2sd_back #(
    parameter int MAX_DIGITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    output logic                                q_pop,
    input  b2sd_pkg::info_t                     q_info,
    input  logic [MAX_DIGITS-1:0][3:0]          q_digits,
    input  logic [3:0]                          numeral_system,
    output logic                                empty,
    input  logic                                pop,
    output logic [b2sd_pkg::BYTE_W-1:0]         out_byte,
    output logic                                last,
    output logic                                overflow,
    output logic [b2sd_pkg::LEN_W-1:0]          total_length
);
    import b2sd_pkg::*;

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    localparam logic [1:0] SUB_LEAD0 = 2'd0;
    localparam logic [1:0] SUB_LEAD1 = 2'd1;
    localparam logic [1:0] SUB_FINAL = 2'd2;

    logic                       busy_reg, busy_next;
    info_t                      info_reg, info_next;
    logic [MAX_DIGITS-1:0][3:0] dig_reg, dig_next;
    logic [IDX_W-1:0]           ptr_reg, ptr_next;
    logic [1:0]                 sub_reg, sub_next;

    logic                       ov_reg, ov_next;
    logic [BYTE_W-1:0]          byte_reg, byte_next;
    logic                       last_reg, last_next;
    logic                       ovf_reg, ovf_next;
    logic [LEN_W-1:0]           len_reg, len_next;

    logic                       advance;
    logic                       fin;
    logic [3:0]                 cur_digit;
    script_t                    scr;

    assign scr     = script_lookup(numeral_system);
    assign advance = !ov_reg || pop;
    assign fin     = (ptr_reg == '0);
    assign q_pop   = !busy_reg && !q_empty;

    always_comb
    begin
        cur_digit = 4'd0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (ptr_reg == IDX_W'(i))
            begin
                cur_digit = dig_reg[i];
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        info_next = info_reg;
        dig_next  = dig_reg;
        ptr_next  = ptr_reg;
        sub_next  = sub_reg;
        ov_next   = ov_reg;
        byte_next = byte_reg;
        last_next = last_reg;
        ovf_next  = ovf_reg;
        len_next  = len_reg;

        if (q_pop)
        begin
            busy_next = 1'b1;
            info_next = q_info;
            dig_next  = q_digits;
            ptr_next  = IDX_W'(q_info.nd - ND_W'(1));
            sub_next  = SUB_LEAD0;
        end

        if (advance)
        begin
            ov_next = 1'b0;
            if (busy_reg)
            begin
                ov_next   = 1'b1;
                last_next = 1'b0;
                ovf_next  = 1'b0;
                len_next  = '0;
                if (info_reg.ovf)
                begin
                    byte_next = '0;
                    last_next = 1'b1;
                    ovf_next  = 1'b1;
                    busy_next = 1'b0;
                end
                else
                begin
                    unique case (sub_reg)
                        SUB_LEAD0:
                        begin
                            byte_next = scr.lead0;
                            sub_next  = scr.three ? SUB_LEAD1 : SUB_FINAL;
                        end
                        SUB_LEAD1:
                        begin
                            byte_next = scr.lead1;
                            sub_next  = SUB_FINAL;
                        end
                        SUB_FINAL:
                        begin
                            byte_next = scr.zero + BYTE_W'(cur_digit);
                            sub_next  = SUB_LEAD0;
                            if (fin)
                            begin
                                last_next = 1'b1;
                                len_next  = info_reg.total;
                                busy_next = 1'b0;
                            end
                            else
                            begin
                                ptr_next = ptr_reg - IDX_W'(1);
                            end
                        end
                        default:
                        begin
                            sub_next = SUB_LEAD0;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
            sub_reg  <= SUB_LEAD0;
        end
        else
        begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
            sub_reg  <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        info_reg <= info_next;
        dig_reg  <= dig_next;
        ptr_reg  <= ptr_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        ovf_reg  <= ovf_next;
        len_reg  <= len_next;
    end

    assign empty        = !ov_reg;
    assign out_byte     = byte_reg;
    assign last         = last_reg;
    assign overflow     = ovf_reg;
    assign total_length = len_reg;

    a_ovf_shape: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && ovf_reg |-> last_reg && byte_reg == '0 && len_reg == '0)
        else $error("overflow item malformed");

    a_len_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !last_reg |-> len_reg == '0 && !ovf_reg)
        else $error("length or overflow on non-final byte");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && last_reg && !ovf_reg |-> len_reg != '0)
        else $error("final byte without length");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> busy_reg)
        else $error("queue entry taken but emitter not busy");

endmodule

@@ hw/rtl/binary_to_script_digits_utf8_unit.sv @@
// Path to the first byte: the shifts of the bit-serial BCD converter, the
// classify state, then the queue and the registered emitter output.
// The converter takes a new value only back in idle, after its shifts,
// the classify state and the write of the item into the queue; output
// bytes leave at one per cycle while pop is held.
// Reset clears all control state; numeral_system resets to 0, buffer_bytes
// to 64.
// ----------------------------------------------------------------------------
// binary_to_script_digits_utf8_unit
// Writes an unsigned 64-bit value as decimal digits in one of sixteen
// numeral scripts, as a stream of UTF-8 bytes.
// ----------------------------------------------------------------------------
module binary_to_script_digits_utf8_unit #(
    parameter int MAX_DIGITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [b2sd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [7:0]                          cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic [b2sd_pkg::VALUE_W-1:0]        value,
    output logic                                empty,
    input  logic                                pop,
    output logic [b2sd_pkg::BYTE_W-1:0]         out_byte,
    output logic                                last,
    output logic                                overflow,
    output logic [b2sd_pkg::LEN_W-1:0]          total_length
);
    import b2sd_pkg::*;

    localparam int QW = $bits(info_t) + 4 * MAX_DIGITS;

    logic [3:0]                 sys_reg;
    logic [7:0]                 buf_reg;

    logic                       f_push, f_full;
    info_t                      f_info, b_info;
    logic [MAX_DIGITS-1:0][3:0] f_digits, b_digits;
    logic                       b_pop, b_empty;
    logic [QW-1:0]              q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_reg <= SYS_DEVANAGARI;
            buf_reg <= 8'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUMERAL_SYSTEM: sys_reg <= cfg_data[3:0];
                REG_BUFFER_BYTES:   buf_reg <= cfg_data;
                default:            sys_reg <= sys_reg;
            endcase
        end
    end

    b2sd_front #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .value          (value),
        .numeral_system (sys_reg),
        .buffer_bytes   (buf_reg),
        .q_push         (f_push),
        .q_full         (f_full),
        .q_info         (f_info),
        .q_digits       (f_digits)
    );

    b2sd_queue #(
        .W(QW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (f_push),
        .wdata   ({f_info, f_digits}),
        .q_full  (f_full),
        .rd      (b_pop),
        .rdata   (q_rdata),
        .q_empty (b_empty)
    );

    assign b_info   = q_rdata[QW-1:4*MAX_DIGITS];
    assign b_digits = q_rdata[4*MAX_DIGITS-1:0];

    b2sd_back #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (b_empty),
        .q_pop          (b_pop),
        .q_info         (b_info),
        .q_digits       (b_digits),
        .numeral_system (sys_reg),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .last           (last),
        .overflow       (overflow),
        .total_length   (total_length)
    );

endmodule
